>>> design/gmb_pkg.sv
// ----------------------------------------------------------------------------
// gmb_pkg
// Shared types, codes and helpers for the grid maze backtracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gmb_pkg;

  localparam int MaxSide = 32;
  localparam int SideW   = $clog2(MaxSide);
  localparam int CfgW    = 6;
  localparam int Cells   = MaxSide * MaxSide;
  localparam int CellW   = $clog2(Cells);
  localparam int LevelW  = CellW + 1;
  localparam int CellDw  = 5;   // visited bit over four open-wall bits

  localparam logic [CfgW-1:0] SideReset = CfgW'(20);

  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_STEP  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_DISPATCH,
    ST_START_CLR,
    ST_START,
    ST_LOOK,
    ST_DECIDE,
    ST_POP,
    ST_CARVE,
    ST_READ,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    RD_NB,
    RD_CUR,
    RD_POS
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_START,
    WR_CUR,
    WR_NB
  } wr_sel_e;

  typedef struct packed {
    logic       latch_in;
    rd_sel_e    rd_sel;
    logic [1:0] rd_dir;
    logic       cap_en;
    logic [1:0] cap_dir;
    wr_sel_e    wr_sel;
    logic       clr_step;
    logic       start_init;
    logic       pop;
    logic       pop_load;
    logic       push;
    logic       carve_move;
    logic       set_rej;
    logic       load_walls;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  pos_ok;
    logic  finished;
    logic  any_free;
    logic  dir_free;
    logic  last_pop;
    logic  clr_last;
    logic  out_free;
  } sts_t;

  typedef struct packed {
    logic             ok;
    logic [SideW-1:0] col;
    logic [SideW-1:0] row;
  } nb_t;

  function automatic logic [CfgW-1:0] eff_side(input logic [CfgW-1:0] v);
    logic [CfgW-1:0] r;
    r = v;
    if (v == '0) r = CfgW'(1);
    else if (v > CfgW'(MaxSide)) r = CfgW'(MaxSide);
    return r;
  endfunction

  // neighbour of a cell; ok is low when it falls outside the grid
  function automatic nb_t nb_of(input logic [SideW-1:0] c, input logic [SideW-1:0] r,
                                input logic [CfgW-1:0] w, input logic [CfgW-1:0] h,
                                input logic [1:0] d);
    logic [CfgW-1:0] nc;
    logic [CfgW-1:0] nr;
    nb_t             n;
    nc   = CfgW'(c);
    nr   = CfgW'(r);
    n.ok = 1'b1;
    case (d)
      DIR_N: begin
        if (r == '0) n.ok = 1'b0;
        else nr = nr - CfgW'(1);
      end
      DIR_E: nc = nc + CfgW'(1);
      DIR_S: nr = nr + CfgW'(1);
      default: begin
        if (c == '0) n.ok = 1'b0;
        else nc = nc - CfgW'(1);
      end
    endcase
    if (nc >= w || nr >= h) n.ok = 1'b0;
    n.col = nc[SideW-1:0];
    n.row = nr[SideW-1:0];
    return n;
  endfunction

endpackage

`default_nettype wire

>>> design/gmb_ram.sv
// ----------------------------------------------------------------------------
// gmb_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gmb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/gmb_ctrl.sv
// ----------------------------------------------------------------------------
// gmb_ctrl
// Sequencer: clearing sweeps, neighbour look-up, pop / carve decisions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gmb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire gmb_pkg::sts_t sts_i,
  output gmb_pkg::cmd_t      cmd_o
);
  import gmb_pkg::*;

  state_e     state_q, state_d;
  logic [2:0] look_q, look_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT_CLR;
      look_q  <= '0;
    end else begin
      state_q <= state_d;
      look_q  <= look_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    look_d     = look_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT_CLR: begin
        cmd_o.wr_sel   = WR_CLEAR;
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts_i.kind)
          KIND_START: begin
            if (!sts_i.pos_ok) begin
              cmd_o.set_rej = 1'b1;
              state_d       = ST_RESP;
            end else begin
              state_d = ST_START_CLR;
            end
          end
          KIND_STEP: begin
            look_d  = '0;
            state_d = sts_i.finished ? ST_RESP : ST_LOOK;
          end
          KIND_READ: begin
            if (!sts_i.pos_ok) begin
              cmd_o.set_rej = 1'b1;
              state_d       = ST_RESP;
            end else begin
              cmd_o.rd_sel = RD_POS;
              state_d      = ST_READ;
            end
          end
          default: state_d = ST_RESP;
        endcase
      end
      ST_START_CLR: begin
        cmd_o.wr_sel   = WR_CLEAR;
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_START;
      end
      ST_START: begin
        cmd_o.wr_sel     = WR_START;
        cmd_o.start_init = 1'b1;
        state_d          = ST_RESP;
      end
      ST_LOOK: begin
        // issue one neighbour read a cycle, capture the one issued before
        cmd_o.rd_sel  = (look_q == 3'd4) ? RD_CUR : RD_NB;
        cmd_o.rd_dir  = look_q[1:0];
        cmd_o.cap_en  = (look_q != 3'd0);
        cmd_o.cap_dir = look_q[1:0] - 2'd1;
        if (look_q == 3'd4) state_d = ST_DECIDE;
        else look_d = look_q + 3'd1;
      end
      ST_DECIDE: begin
        if (!sts_i.any_free) begin
          cmd_o.pop = 1'b1;
          state_d   = sts_i.last_pop ? ST_RESP : ST_POP;
        end else if (sts_i.dir_free) begin
          cmd_o.wr_sel = WR_CUR;
          cmd_o.push   = 1'b1;
          state_d      = ST_CARVE;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_POP: begin
        cmd_o.pop_load = 1'b1;
        state_d        = ST_RESP;
      end
      ST_CARVE: begin
        cmd_o.wr_sel     = WR_NB;
        cmd_o.carve_move = 1'b1;
        state_d          = ST_RESP;
      end
      ST_READ: begin
        cmd_o.load_walls = 1'b1;
        state_d          = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> design/gmb_dp.sv
// ----------------------------------------------------------------------------
// gmb_dp
// Datapath: grid registers, cursor, stack level, cell and stack memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gmb_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire gmb_pkg::cmd_t               cmd_i,
  output gmb_pkg::sts_t                    sts_o,
  input  wire logic                        cfg_valid_i,
  input  wire logic                        cfg_index_i,
  input  wire logic [gmb_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic [1:0]                  kind_i,
  input  wire logic [1:0]                  direction_i,
  input  wire logic [gmb_pkg::SideW-1:0]   pos_x_i,
  input  wire logic [gmb_pkg::SideW-1:0]   pos_y_i,
  input  wire logic                        out_ready_i,
  output logic                             out_valid_o,
  output logic      [gmb_pkg::SideW-1:0]   cur_x_o,
  output logic      [gmb_pkg::SideW-1:0]   cur_y_o,
  output logic                             carved_o,
  output logic                             backtracked_o,
  output logic                             done_res_o,
  output logic      [3:0]                  cell_walls_o,
  output logic                             rejected_o
);
  import gmb_pkg::*;

  logic [CfgW-1:0]   width_q, height_q;
  logic [CfgW-1:0]   w, h;
  kind_e             kind_q;
  logic [1:0]        dir_q;
  logic [SideW-1:0]  px_q, py_q;
  logic [SideW-1:0]  col_q, row_q;
  logic [LevelW-1:0] level_q, level_m2;
  logic              finished_q;
  logic [3:0]        free_q;
  logic              carved_q, back_q, rej_q;
  logic [3:0]        walls_q;
  logic [CellW-1:0]  clr_addr_q;
  logic              out_valid_q;

  nb_t               nb_rd, nb_cap, nb_dir;
  logic [1:0]        opp;
  logic              cell_we;
  logic [CellW-1:0]  cell_waddr, cell_raddr;
  logic [CellDw-1:0] cell_wdata, cell_rd;
  logic              stk_we;
  logic [CellW-1:0]  stk_waddr;
  logic [CellW-1:0]  stk_wdata, stk_rd;
  logic              can_push;

  assign w        = eff_side(width_q);
  assign h        = eff_side(height_q);
  assign nb_rd    = nb_of(col_q, row_q, w, h, cmd_i.rd_dir);
  assign nb_cap   = nb_of(col_q, row_q, w, h, cmd_i.cap_dir);
  assign nb_dir   = nb_of(col_q, row_q, w, h, dir_q);
  assign opp      = dir_q + 2'd2;
  assign level_m2 = level_q - LevelW'(2);
  assign can_push = (level_q < LevelW'(Cells));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SideReset;
      height_q <= SideReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i) height_q <= cfg_data_i;
      else width_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      kind_q <= kind_e'(kind_i);
      dir_q  <= direction_i;
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      level_q    <= '0;
      finished_q <= 1'b1;
      free_q     <= '0;
      carved_q   <= 1'b0;
      back_q     <= 1'b0;
      rej_q      <= 1'b0;
      walls_q    <= '0;
      clr_addr_q <= '0;
    end else begin
      if (cmd_i.latch_in) begin
        carved_q <= 1'b0;
        back_q   <= 1'b0;
        rej_q    <= 1'b0;
        walls_q  <= '0;
      end
      if (cmd_i.clr_step) clr_addr_q <= clr_addr_q + CellW'(1);
      if (cmd_i.cap_en) free_q[cmd_i.cap_dir] <= nb_cap.ok && !cell_rd[CellDw-1];
      if (cmd_i.set_rej) rej_q <= 1'b1;
      if (cmd_i.load_walls) walls_q <= cell_rd[3:0];
      if (cmd_i.start_init) begin
        col_q      <= px_q;
        row_q      <= py_q;
        level_q    <= LevelW'(1);
        finished_q <= 1'b0;
      end
      if (cmd_i.pop) begin
        back_q <= 1'b1;
        if (level_q != '0) level_q <= level_q - LevelW'(1);
        if (level_q <= LevelW'(1)) finished_q <= 1'b1;
      end
      if (cmd_i.pop_load) begin
        col_q <= stk_rd[SideW-1:0];
        row_q <= stk_rd[CellW-1:SideW];
      end
      if (cmd_i.carve_move) begin
        col_q    <= nb_dir.col;
        row_q    <= nb_dir.row;
        carved_q <= 1'b1;
        if (can_push) level_q <= level_q + LevelW'(1);
      end
    end
  end

  // cell store address and data selection
  always_comb begin
    case (cmd_i.rd_sel)
      RD_NB:   cell_raddr = {nb_rd.row, nb_rd.col};
      RD_POS:  cell_raddr = {py_q, px_q};
      default: cell_raddr = {row_q, col_q};
    endcase
    cell_we    = 1'b1;
    cell_waddr = clr_addr_q;
    cell_wdata = '0;
    case (cmd_i.wr_sel)
      WR_CLEAR: ;
      WR_START: begin
        cell_waddr = {py_q, px_q};
        cell_wdata = {1'b1, 4'b0000};
      end
      WR_CUR: begin
        cell_waddr = {row_q, col_q};
        cell_wdata = {1'b1, cell_rd[3:0] | (4'b0001 << dir_q)};
      end
      WR_NB: begin
        cell_waddr = {nb_dir.row, nb_dir.col};
        cell_wdata = {1'b1, 4'b0001 << opp};
      end
      default: cell_we = 1'b0;
    endcase
  end

  assign stk_we    = cmd_i.start_init || (cmd_i.push && can_push);
  assign stk_waddr = cmd_i.start_init ? '0 : level_q[CellW-1:0];
  assign stk_wdata = cmd_i.start_init ? {py_q, px_q} : {nb_dir.row, nb_dir.col};

  gmb_ram #(.Width(CellDw), .Depth(Cells)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rd)
  );

  gmb_ram #(.Width(CellW), .Depth(Cells)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (level_m2[CellW-1:0]),
    .rdata_o (stk_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      cur_x_o       <= col_q;
      cur_y_o       <= row_q;
      carved_o      <= carved_q;
      backtracked_o <= back_q;
      done_res_o    <= finished_q;
      cell_walls_o  <= walls_q;
      rejected_o    <= rej_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.kind     = kind_q;
    sts_o.pos_ok   = (CfgW'(px_q) < w) && (CfgW'(py_q) < h);
    sts_o.finished = finished_q;
    sts_o.any_free = |free_q;
    sts_o.dir_free = free_q[dir_q];
    sts_o.last_pop = (level_q <= LevelW'(1));
    sts_o.clr_last = &clr_addr_q;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

>>> design/grid_maze_backtracker.sv
// ----------------------------------------------------------------------------
// grid_maze_backtracker
// Randomised depth-first maze carver over a grid of up to 32 x 32 cells.
// ----------------------------------------------------------------------------
// Usage: a request on the input channel is a start (clear the maze and put
// the cursor on pos_x/pos_y), a carve step carrying a random direction, or a
// read of one cell's open walls. Every request gives exactly one result on
// the output channel. grid_width / grid_height are written through the cfg
// channel (index 0 and 1) while the block is idle; cfg_ready_o is always high.
// Path from acceptance to result valid: a read addresses the cell store and
// loads the wall bits; a step makes five reads of the single cell-store
// port, then a pop or a carve if it has one; a start runs the sweep that
// clears all 1024 cells of the cell store; a rejected position, a step once
// finished and the unused kind go straight from dispatch to the result.
// One request is in flight at a time; the next is accepted as soon as the
// result is in the output register, even while that result waits.
// After reset the same sweep runs and in_ready_o stays low until it ends.
// A stalled receiver holds the result in the output register and the block
// waits before it delivers the one after.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_maze_backtracker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic                        cfg_index_i,
  input  wire logic [gmb_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  kind_i,
  input  wire logic [1:0]                  direction_i,
  input  wire logic [gmb_pkg::SideW-1:0]   pos_x_i,
  input  wire logic [gmb_pkg::SideW-1:0]   pos_y_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [gmb_pkg::SideW-1:0]   cur_x_o,
  output logic      [gmb_pkg::SideW-1:0]   cur_y_o,
  output logic                             carved_o,
  output logic                             backtracked_o,
  output logic                             done_res_o,
  output logic      [3:0]                  cell_walls_o,
  output logic                             rejected_o
);
  import gmb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  gmb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gmb_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .kind_i        (kind_i),
    .direction_i   (direction_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .cur_x_o       (cur_x_o),
    .cur_y_o       (cur_y_o),
    .carved_o      (carved_o),
    .backtracked_o (backtracked_o),
    .done_res_o    (done_res_o),
    .cell_walls_o  (cell_walls_o),
    .rejected_o    (rejected_o)
  );

  a_carve_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && carved_o |-> !done_res_o && !backtracked_o)
    else $error("carve reported together with pop or finish");

  a_reject_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> !carved_o && !backtracked_o && cell_walls_o == 4'd0)
    else $error("rejected request changed the maze");

  a_walls_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cell_walls_o != 4'd0 |-> !carved_o && !backtracked_o)
    else $error("wall bits reported on a carve step");

endmodule

`default_nettype wire

>>> verif/tb_grid_maze_backtracker.sv
// ----------------------------------------------------------------------------
// tb_grid_maze_backtracker
// Self-checking bench for the maze carver: random starts, carve walks, wall
// reads and grid resizes, each result compared with an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import gmb_pkg::*;

class maze_scoreboard;
  logic [5:0]  width_reg;
  logic [5:0]  height_reg;
  bit          visited [Cells];
  logic [3:0]  walls   [Cells];
  int unsigned trail   [Cells];
  int unsigned depth;
  int unsigned cur_col;
  int unsigned cur_row;
  bit          finished;
  logic [17:0] pending_results [$];
  int          error_count;

  function new();
    width_reg   = SideReset;
    height_reg  = SideReset;
    depth       = 0;
    cur_col     = 0;
    cur_row     = 0;
    finished    = 1;
    error_count = 0;
    foreach (visited[i]) begin
      visited[i] = 0;
      walls[i]   = '0;
    end
  endfunction

  function int unsigned side_in_use(logic [5:0] v);
    if (v == 0) return 1;
    if (v > MaxSide) return MaxSide;
    return v;
  endfunction

  // neighbour of the cursor; -1 when outside the grid
  function int neighbour_cell(logic [1:0] d, int unsigned w, int unsigned h);
    int c;
    int r;
    c = cur_col;
    r = cur_row;
    case (d)
      DIR_N: r = r - 1;
      DIR_E: c = c + 1;
      DIR_S: r = r + 1;
      default: c = c - 1;
    endcase
    if (c < 0 || r < 0 || c >= w || r >= h) return -1;
    return r * MaxSide + c;
  endfunction

  function bit unvisited_nb(logic [1:0] d, int unsigned w, int unsigned h);
    int n;
    n = neighbour_cell(d, w, h);
    return n >= 0 && !visited[n];
  endfunction

  function void note_config(bit idx, logic [5:0] val);
    if (idx == 0) width_reg = val;
    else height_reg = val;
  endfunction

  function void note_request(logic [1:0] kind, logic [1:0] dir, logic [4:0] px,
                             logic [4:0] py);
    int unsigned w;
    int unsigned h;
    bit          carved;
    bit          back;
    bit          rej;
    bit          any;
    logic [3:0]  rd_walls;
    int          n;
    logic [17:0] res;
    w = side_in_use(width_reg);
    h = side_in_use(height_reg);
    carved = 0; back = 0; rej = 0; rd_walls = '0;
    if (kind == KIND_START) begin
      if (px >= w || py >= h) rej = 1;
      else begin
        foreach (visited[i]) begin
          visited[i] = 0;
          walls[i]   = '0;
        end
        cur_col = px;
        cur_row = py;
        visited[py * MaxSide + px] = 1;
        trail[0] = py * MaxSide + px;
        depth = 1;
        finished = 0;
      end
    end else if (kind == KIND_STEP && !finished) begin
      any = 0;
      for (int d = 0; d < 4; d++) if (unvisited_nb(2'(d), w, h)) any = 1;
      if (!any) begin
        back = 1;
        if (depth > 0) depth--;
        if (depth == 0) finished = 1;
        else begin
          cur_col = trail[depth - 1] % MaxSide;
          cur_row = trail[depth - 1] / MaxSide;
        end
      end else if (unvisited_nb(dir, w, h)) begin
        n = neighbour_cell(dir, w, h);
        walls[cur_row * MaxSide + cur_col][dir] = 1'b1;
        walls[n][dir + 2'd2] = 1'b1;
        visited[n] = 1;
        trail[depth] = n;
        depth++;
        cur_col = n % MaxSide;
        cur_row = n / MaxSide;
        carved = 1;
      end
    end else if (kind == KIND_READ) begin
      if (px >= w || py >= h) rej = 1;
      else rd_walls = walls[py * MaxSide + px];
    end
    res = {5'(cur_col), 5'(cur_row), carved, back, finished, rd_walls, rej};
    pending_results = {pending_results, res};
  endfunction

  task report(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  task check_result(logic [17:0] got);
    logic [17:0] want;
    if (pending_results.size() == 0) begin
      report("unexpected result", int'(got), 0);
      return;
    end
    want = pending_results.pop_front();
    if (got[17:13] !== want[17:13]) report("cur_x", int'(got[17:13]), int'(want[17:13]));
    if (got[12:8] !== want[12:8]) report("cur_y", int'(got[12:8]), int'(want[12:8]));
    if (got[7] !== want[7]) report("carved", int'(got[7]), int'(want[7]));
    if (got[6] !== want[6]) report("backtracked", int'(got[6]), int'(want[6]));
    if (got[5] !== want[5]) report("done_res", int'(got[5]), int'(want[5]));
    if (got[4:1] !== want[4:1]) report("cell_walls", int'(got[4:1]), int'(want[4:1]));
    if (got[0] !== want[0]) report("rejected", int'(got[0]), int'(want[0]));
  endtask
endclass

module tb_grid_maze_backtracker;
  localparam int WatchLimit = 20000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_index_i = 1'b0;
  logic [5:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] kind_i = '0;
  logic [1:0] direction_i = '0;
  logic [4:0] pos_x_i = '0;
  logic [4:0] pos_y_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [4:0] cur_x_o;
  logic [4:0] cur_y_o;
  logic       carved_o;
  logic       backtracked_o;
  logic       done_res_o;
  logic [3:0] cell_walls_o;
  logic       rejected_o;

  maze_scoreboard sb = new();
  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_off_cycles;
  int  quiet_cycles;
  int  walk_w;
  int  walk_h;

  grid_maze_backtracker dut (.*);

  always #1 clk_i = ~clk_i;

  // receiver: random stalls, plus an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({cur_x_o, cur_y_o, carved_o, backtracked_o, done_res_o,
                       cell_walls_o, rejected_o});
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // valid is dropped only by an idle cycle or by drain, never twice per edge
  task send_request(logic [1:0] kind, logic [1:0] dir, logic [4:0] px, logic [4:0] py);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    direction_i <= dir;
    pos_x_i     <= px;
    pos_y_i     <= py;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(kind, dir, px, py);
    @(negedge clk_i);
  endtask

  task drain();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task write_reg(bit idx, logic [5:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_config(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly well-formed walks: one start, then many carve steps and reads
  task random_walk(int n_steps);
    int sel;
    send_request(KIND_START, 2'($urandom), 5'($urandom_range(walk_w - 1)),
                 5'($urandom_range(walk_h - 1)));
    for (int i = 0; i < n_steps; i++) begin
      sel = $urandom_range(99);
      if (sel < 75) send_request(KIND_STEP, 2'($urandom), 5'($urandom), 5'($urandom));
      else if (sel < 93)
        send_request(KIND_READ, 2'($urandom), 5'($urandom_range(walk_w)),
                     5'($urandom_range(walk_h)));
      else send_request(2'($urandom), 2'($urandom), 5'($urandom), 5'($urandom));
    end
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_cycles = 0;
    quiet_cycles = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: tiny grid, dead ends, finish, out-of-grid and unused kind
    write_reg(0, 6'd2);
    write_reg(1, 6'd2);
    send_request(KIND_STEP, DIR_N, '0, '0);
    send_request(KIND_START, DIR_N, 5'd2, 5'd0);
    send_request(KIND_READ, DIR_N, 5'd0, 5'd2);
    send_request(KIND_START, DIR_N, 5'd1, 5'd1);
    send_request(KIND_STEP, DIR_S, '0, '0);
    send_request(KIND_STEP, DIR_N, '0, '0);
    send_request(KIND_STEP, DIR_E, '0, '0);
    send_request(KIND_STEP, DIR_W, '0, '0);
    send_request(KIND_STEP, DIR_S, '0, '0);
    for (int i = 0; i < 5; i++) send_request(KIND_STEP, 2'(i), '0, '0);
    send_request(KIND_READ, DIR_N, 5'd0, 5'd0);
    send_request(KIND_READ, DIR_N, 5'd1, 5'd1);
    send_request(KIND_NONE, DIR_W, 5'd31, 5'd31);
    write_reg(0, 6'd0);
    write_reg(1, 6'd63);
    send_request(KIND_START, DIR_E, 5'd0, 5'd31);
    send_request(KIND_STEP, DIR_S, '0, '0);
    send_request(KIND_STEP, DIR_N, '0, '0);
    send_request(KIND_READ, DIR_N, 5'd0, 5'd31);
    // shrink the grid under the cursor
    write_reg(1, 6'd4);
    send_request(KIND_STEP, DIR_N, '0, '0);
    send_request(KIND_STEP, DIR_E, '0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 53 : 0;
      recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 10 : 0;
      for (int k = 0; k < 4; k++) begin
        case (k)
          0: begin walk_w = 32; walk_h = 32; end
          1: begin walk_w = 1; walk_h = $urandom_range(1, 32); end
          2: begin walk_w = $urandom_range(1, 5); walk_h = $urandom_range(1, 5); end
          default: begin walk_w = $urandom_range(1, 32); walk_h = $urandom_range(1, 32); end
        endcase
        write_reg(0, 6'(walk_w));
        write_reg(1, 6'(walk_h));
        if (phase == 2 && k == 0) hold_off_cycles = 400;
        random_walk(30);
        if (k == 1) drain();
      end
    end

    drain();
    if (sb.error_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

>>> sim.f
design/gmb_pkg.sv
design/gmb_ram.sv
design/gmb_ctrl.sv
design/gmb_dp.sv
design/grid_maze_backtracker.sv
verif/tb_grid_maze_backtracker.sv
